[rtl/dfsp_pkg.sv]
// shared types, constants and the crc step function for the fib service parser
// used by dfsp_ctrl, dfsp_dp and dab_fib_service_parser_top; no dependencies
package dfsp_pkg;

  localparam int MaxServices = 64;
  localparam int MaxResults  = 12;
  localparam int SvcIdxW     = (MaxServices > 1) ? $clog2(MaxServices) : 1;
  localparam int CntW        = $clog2(MaxServices + 1);
  localparam int TxtAw       = SvcIdxW + 1;
  localparam int FibBytes    = 32;
  localparam int CrcBytes    = 30;
  localparam int Fig1Len     = 21;
  localparam int OutW        = 112;
  localparam logic [7:0] EndMarker = 8'hFF;
  localparam logic [4:0] Fig0Ext   = 5'd2;
  localparam logic [5:0] AsctyPlus = 6'h3F;

  typedef enum logic [2:0] {
    EvEnsemble   = 3'd0,
    EvService    = 3'd1,
    EvCrcError   = 3'd2,
    EvMisaligned = 3'd3,
    EvTableFull  = 3'd4
  } event_kind_e;

  typedef enum logic [2:0] {
    EmMisalign,
    EmCrc,
    EmFull,
    EmEns0,
    EmEns1,
    EmSvc0,
    EmSvc1
  } emit_sel_e;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] ident;
    logic [5:0]  subchannel;
    logic        dab_plus;
    logic [3:0]  label_charset;
    logic [15:0] short_mask;
    logic [63:0] label_part;
    logic        part_index;
  } item_t;

  typedef struct packed {
    logic               accept;
    logic [4:0]         rd_addr;
    logic               cap_shift;
    logic               key_hi;
    logic               key_lo;
    logic               key_cap;
    logic               cand_load;
    logic               cand_plus;
    logic [CntW-1:0]    idx;
    logic               am_rd;
    logic               lm_rd;
    logic               am_wr;
    logic               lm_wr;
    logic               tm_wr;
    logic               tm_rd;
    logic               tm_hi;
    logic               rep_label;
    logic               rep_t0;
    logic               rep_t1;
    logic               rep_cap;
    logic               rep_audio;
    logic               set_rep;
    logic [SvcIdxW-1:0] rep_idx;
    logic               ens_upd;
    logic               emit;
    emit_sel_e          em_sel;
    logic               finish;
  } cmd_t;

  typedef struct packed {
    logic [7:0]      rd_byte;
    logic            pos_last;
    logic            crc_ok;
    logic            a_match;
    logic            l_match;
    logic [CntW-1:0] audio_cnt;
    logic [CntW-1:0] label_cnt;
    logic            rep_flag;
    logic            ens_diff;
    logic [7:0]      cap_hdr;
    logic            emit_ready;
    logic            fin_ready;
    logic            pend_v;
  } sts_t;

  // one byte of crc-16 ccitt, msb first, polynomial 0x1021
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[rtl/dfsp_ctrl.sv]
// controller state machine: fib completion, fig walk, table searches, result sequencing
// depends on dfsp_pkg; drives dfsp_dp through cmd_t and reads sts_t
module dfsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  dfsp_pkg::sts_t sts_i,
  output dfsp_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CRC, ST_FIG_HDR, ST_F0_HDR, ST_F0_SVC, ST_F0_SID1, ST_F0_N,
    ST_F0_COMP, ST_F0_COMP1, ST_S_RD, ST_S_CMP, ST_T0, ST_T1, ST_T2,
    ST_F1_CHK, ST_F1_RD, ST_F1_EVAL, ST_F1_W0, ST_F1_W1, ST_EMIT, ST_FIN
  } state_e;

  typedef enum logic [1:0] {P_A0, P_L0, P_L1, P_A1} purp_e;

  state_e                    state_q, state_d, ret_q, ret_d;
  purp_e                     purp_q, purp_d;
  dfsp_pkg::emit_sel_e       em_q, em_d;
  logic [5:0]                off_q, off_d, p_q, p_d, end_q, end_d, pos_q, pos_d;
  logic [4:0]                len_q, len_d, cnt_q, cnt_d;
  logic [3:0]                n_q, n_d;
  logic                      pd_q, pd_d;
  logic [7:0]                b0_q, b0_d;
  logic [dfsp_pkg::CntW-1:0] idx_q, idx_d;
  logic [dfsp_pkg::SvcIdxW-1:0] new_a_q, new_a_d;

  logic [5:0]                p_nxt;
  logic [6:0]                fig_sum;
  logic [dfsp_pkg::CntW-1:0] tbl_cnt;
  logic                      comp_ok;
  logic                      audio_full, label_full;

  assign audio_full = (sts_i.audio_cnt == dfsp_pkg::CntW'(dfsp_pkg::MaxServices));
  assign label_full = (sts_i.label_cnt == dfsp_pkg::CntW'(dfsp_pkg::MaxServices));

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    purp_d  = purp_q;
    em_d    = em_q;
    off_d   = off_q;
    p_d     = p_q;
    end_d   = end_q;
    pos_d   = pos_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    pd_d    = pd_q;
    b0_d    = b0_q;
    idx_d   = idx_q;
    new_a_d = new_a_q;
    in_ready_o = 1'b0;
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    cmd_o.rep_idx = new_a_q;
    cmd_o.em_sel  = em_q;
    p_nxt   = off_q + 6'd1;
    fig_sum = {1'b0, p_nxt} + {2'b00, sts_i.rd_byte[4:0]};
    tbl_cnt = ((purp_q == P_A0) || (purp_q == P_A1)) ? sts_i.audio_cnt : sts_i.label_cnt;
    comp_ok = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.pos_last) begin
            state_d = ST_CRC;
          end else if (in_last_i) begin
            em_d    = dfsp_pkg::EmMisalign;
            ret_d   = ST_FIN;
            state_d = ST_EMIT;
          end
        end
      end
      ST_CRC: begin
        if (!sts_i.crc_ok) begin
          em_d    = dfsp_pkg::EmCrc;
          ret_d   = ST_FIN;
          state_d = ST_EMIT;
        end else begin
          off_d   = 6'd0;
          state_d = ST_FIG_HDR;
        end
      end
      ST_FIG_HDR: begin
        cmd_o.rd_addr = off_q[4:0];
        if ((off_q >= 6'(dfsp_pkg::CrcBytes)) || (sts_i.rd_byte == dfsp_pkg::EndMarker)) begin
          state_d = ST_FIN;
        end else begin
          p_d   = p_nxt;
          len_d = sts_i.rd_byte[4:0];
          end_d = (fig_sum > 7'(dfsp_pkg::CrcBytes)) ? 6'(dfsp_pkg::CrcBytes) : fig_sum[5:0];
          off_d = fig_sum[5:0];
          if (sts_i.rd_byte[4:0] != 5'd0) begin
            if (sts_i.rd_byte[7:5] == 3'd0) begin
              state_d = ST_F0_HDR;
            end else if (sts_i.rd_byte[7:5] == 3'd1) begin
              state_d = ST_F1_CHK;
            end
          end
        end
      end
      ST_F0_HDR: begin
        cmd_o.rd_addr = p_q[4:0];
        if ((p_q >= end_q) || (sts_i.rd_byte[7:6] != 2'd0) ||
            (sts_i.rd_byte[4:0] != dfsp_pkg::Fig0Ext)) begin
          state_d = ST_FIG_HDR;
        end else begin
          pd_d    = sts_i.rd_byte[5];
          pos_d   = p_q + 6'd1;
          state_d = ST_F0_SVC;
        end
      end
      ST_F0_SVC: begin
        cmd_o.rd_addr = pos_q[4:0];
        if ((pos_q >= end_q) ||
            (({1'b0, pos_q} + (pd_q ? 7'd5 : 7'd3)) > {1'b0, end_q})) begin
          state_d = ST_FIG_HDR;
        end else if (pd_q) begin
          pos_d   = pos_q + 6'd4;
          state_d = ST_F0_N;
        end else begin
          cmd_o.key_hi = 1'b1;
          state_d      = ST_F0_SID1;
        end
      end
      ST_F0_SID1: begin
        cmd_o.rd_addr = pos_q[4:0] + 5'd1;
        cmd_o.key_lo  = 1'b1;
        pos_d         = pos_q + 6'd2;
        state_d       = ST_F0_N;
      end
      ST_F0_N: begin
        cmd_o.rd_addr = pos_q[4:0];
        n_d           = sts_i.rd_byte[3:0];
        pos_d         = pos_q + 6'd1;
        state_d       = ST_F0_COMP;
      end
      ST_F0_COMP: begin
        cmd_o.rd_addr = pos_q[4:0];
        if (n_q == 4'd0) begin
          state_d = ST_F0_SVC;
        end else if (({1'b0, pos_q} + 7'd2) > {1'b0, end_q}) begin
          state_d = ST_FIG_HDR;
        end else begin
          b0_d    = sts_i.rd_byte;
          state_d = ST_F0_COMP1;
        end
      end
      ST_F0_COMP1: begin
        cmd_o.rd_addr = pos_q[4:0] + 5'd1;
        n_d   = n_q - 4'd1;
        pos_d = pos_q + 6'd2;
        // programme audio component: tmid 0, primary, no ca, ascty dab or dab+
        comp_ok = !pd_q && (b0_q[7:6] == 2'd0) && sts_i.rd_byte[1] && !sts_i.rd_byte[0] &&
                  ((b0_q[5:0] == 6'd0) || (b0_q[5:0] == dfsp_pkg::AsctyPlus));
        if (comp_ok) begin
          cmd_o.cand_load = 1'b1;
          cmd_o.cand_plus = (b0_q[5:0] == dfsp_pkg::AsctyPlus);
          purp_d  = P_A0;
          idx_d   = '0;
          state_d = ST_S_RD;
        end else begin
          state_d = ST_F0_COMP;
        end
      end
      ST_S_RD: begin
        if (idx_q == tbl_cnt) begin
          case (purp_q)
            P_A0: begin
              if (audio_full) begin
                em_d    = dfsp_pkg::EmFull;
                ret_d   = ST_F0_COMP;
                state_d = ST_EMIT;
              end else begin
                cmd_o.am_wr = 1'b1;
                new_a_d     = sts_i.audio_cnt[dfsp_pkg::SvcIdxW-1:0];
                purp_d      = P_L0;
                idx_d       = '0;
              end
            end
            P_L0: state_d = ST_F0_COMP;
            P_L1: begin
              if (label_full) begin
                em_d    = dfsp_pkg::EmFull;
                ret_d   = ST_FIG_HDR;
                state_d = ST_EMIT;
              end else begin
                state_d = ST_F1_W0;
              end
            end
            default: state_d = ST_FIG_HDR;
          endcase
        end else begin
          cmd_o.am_rd = (purp_q == P_A0) || (purp_q == P_A1);
          cmd_o.lm_rd = (purp_q == P_L0) || (purp_q == P_L1);
          state_d     = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        if (cmd_o.idx == idx_q && (((purp_q == P_A0) || (purp_q == P_A1)) ? sts_i.a_match
                                                                           : sts_i.l_match)) begin
          case (purp_q)
            P_A0: state_d = ST_F0_COMP;
            P_L0: begin
              cmd_o.rep_label = 1'b1;
              cmd_o.set_rep   = 1'b1;
              state_d         = ST_T0;
            end
            P_L1: state_d = ST_FIG_HDR;
            default: begin
              if (!sts_i.rep_flag) begin
                cmd_o.set_rep   = 1'b1;
                cmd_o.rep_idx   = idx_q[dfsp_pkg::SvcIdxW-1:0];
                cmd_o.rep_audio = 1'b1;
                em_d            = dfsp_pkg::EmSvc0;
                ret_d           = ST_FIG_HDR;
                state_d         = ST_EMIT;
              end else begin
                state_d = ST_FIG_HDR;
              end
            end
          endcase
        end else begin
          idx_d   = idx_q + dfsp_pkg::CntW'(1);
          state_d = ST_S_RD;
        end
      end
      ST_T0: begin
        cmd_o.tm_rd = 1'b1;
        state_d     = ST_T1;
      end
      ST_T1: begin
        cmd_o.rep_t0 = 1'b1;
        cmd_o.tm_rd  = 1'b1;
        cmd_o.tm_hi  = 1'b1;
        state_d      = ST_T2;
      end
      ST_T2: begin
        cmd_o.rep_t1 = 1'b1;
        em_d         = dfsp_pkg::EmSvc0;
        ret_d        = ST_F0_COMP;
        state_d      = ST_EMIT;
      end
      ST_F1_CHK: begin
        if ((len_q != 5'(dfsp_pkg::Fig1Len)) ||
            (({1'b0, p_q} + 7'(dfsp_pkg::Fig1Len)) > 7'(dfsp_pkg::CrcBytes))) begin
          state_d = ST_FIG_HDR;
        end else begin
          cnt_d   = 5'd0;
          state_d = ST_F1_RD;
        end
      end
      ST_F1_RD: begin
        cmd_o.rd_addr   = p_q[4:0] + cnt_q;
        cmd_o.cap_shift = 1'b1;
        cnt_d           = cnt_q + 5'd1;
        if (cnt_q == 5'(dfsp_pkg::Fig1Len - 1)) begin
          state_d = ST_F1_EVAL;
        end
      end
      ST_F1_EVAL: begin
        if ((sts_i.cap_hdr[2:1] != 2'd0) || sts_i.cap_hdr[3]) begin
          state_d = ST_FIG_HDR;
        end else if (!sts_i.cap_hdr[0]) begin
          if (sts_i.ens_diff) begin
            cmd_o.ens_upd = 1'b1;
            em_d          = dfsp_pkg::EmEns0;
            ret_d         = ST_FIG_HDR;
            state_d       = ST_EMIT;
          end else begin
            state_d = ST_FIG_HDR;
          end
        end else begin
          cmd_o.key_cap = 1'b1;
          cmd_o.rep_cap = 1'b1;
          purp_d        = P_L1;
          idx_d         = '0;
          state_d       = ST_S_RD;
        end
      end
      ST_F1_W0: begin
        cmd_o.tm_wr = 1'b1;
        state_d     = ST_F1_W1;
      end
      ST_F1_W1: begin
        cmd_o.tm_wr = 1'b1;
        cmd_o.tm_hi = 1'b1;
        cmd_o.lm_wr = 1'b1;
        purp_d      = P_A1;
        idx_d       = '0;
        state_d     = ST_S_RD;
      end
      ST_EMIT: begin
        if (sts_i.emit_ready) begin
          cmd_o.emit = 1'b1;
          case (em_q)
            dfsp_pkg::EmEns0: em_d = dfsp_pkg::EmEns1;
            dfsp_pkg::EmSvc0: em_d = dfsp_pkg::EmSvc1;
            default:          state_d = ret_q;
          endcase
        end
      end
      ST_FIN: begin
        if (sts_i.fin_ready) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      purp_q  <= P_A0;
      em_q    <= dfsp_pkg::EmCrc;
      off_q   <= '0;
      p_q     <= '0;
      end_q   <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
      pd_q    <= 1'b0;
      b0_q    <= '0;
      idx_q   <= '0;
      new_a_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      purp_q  <= purp_d;
      em_q    <= em_d;
      off_q   <= off_d;
      p_q     <= p_d;
      end_q   <= end_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      pd_q    <= pd_d;
      b0_q    <= b0_d;
      idx_q   <= idx_d;
      new_a_q <= new_a_d;
    end
  end

endmodule

[rtl/dfsp_dp.sv]
// datapath: fib byte store, crc, label capture, service tables, ensemble state, result buffer
// depends on dfsp_pkg; controlled by dfsp_ctrl through cmd_t
module dfsp_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     byte_i,
  input  dfsp_pkg::cmd_t cmd_i,
  output dfsp_pkg::sts_t sts_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic           out_last_o,
  output dfsp_pkg::item_t out_item_o
);

  localparam int Iw = dfsp_pkg::SvcIdxW;
  localparam int Nt = 2 * dfsp_pkg::MaxServices;

  logic [7:0]   fib_q [dfsp_pkg::FibBytes];
  logic [4:0]   pos_q;
  logic [15:0]  crc_q;
  logic [167:0] cap_q;
  logic [15:0]  key_q;
  logic [5:0]   rep_subch_q;
  logic         rep_plus_q;
  logic [3:0]   rep_cs_q;
  logic [15:0]  rep_mask_q;
  logic [63:0]  rep_t0_q, rep_t1_q;

  logic [22:0]  am_mem [dfsp_pkg::MaxServices];
  logic [35:0]  lm_mem [dfsp_pkg::MaxServices];
  logic [63:0]  tm_mem [Nt];
  logic [22:0]  am_rd_q;
  logic [35:0]  lm_rd_q;
  logic [63:0]  tm_rd_q;
  logic [dfsp_pkg::CntW-1:0] audio_cnt_q, label_cnt_q;
  logic [dfsp_pkg::MaxServices-1:0] reported_q;

  logic         ens_known_q;
  logic [15:0]  ens_id_q;
  logic [19:0]  ens_meta_q;
  logic [63:0]  ens_t0_q, ens_t1_q;

  dfsp_pkg::item_t pend_q, out_q, new_item;
  logic         pend_v_q, out_v_q, out_last_q;
  logic [3:0]   res_cnt_q;
  logic         out_free;

  // captured fig 1 fields, first byte in the top bits
  logic [7:0]   cap_h;
  logic [15:0]  cap_id, cap_mask;
  logic [63:0]  cap_t0, cap_t1;
  logic [TxtAw_l-1:0] tm_addr_w, tm_addr_r;
  localparam int TxtAw_l = dfsp_pkg::TxtAw;

  assign cap_h    = cap_q[167:160];
  assign cap_id   = cap_q[159:144];
  assign cap_t0   = cap_q[143:80];
  assign cap_t1   = cap_q[79:16];
  assign cap_mask = cap_q[15:0];

  assign tm_addr_w = {label_cnt_q[Iw-1:0], cmd_i.tm_hi};
  assign tm_addr_r = {cmd_i.idx[Iw-1:0], cmd_i.tm_hi};

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    sts_o            = '0;
    sts_o.rd_byte    = fib_q[cmd_i.rd_addr];
    sts_o.pos_last   = (pos_q == 5'(dfsp_pkg::FibBytes - 1));
    sts_o.crc_ok     = (~crc_q == {fib_q[30], fib_q[31]});
    sts_o.a_match    = (am_rd_q[22:7] == key_q);
    sts_o.l_match    = (lm_rd_q[35:20] == key_q);
    sts_o.audio_cnt  = audio_cnt_q;
    sts_o.label_cnt  = label_cnt_q;
    sts_o.rep_flag   = reported_q[cmd_i.idx[Iw-1:0]];
    sts_o.ens_diff   = !ens_known_q || (cap_id != ens_id_q) ||
                       ({cap_h[7:4], cap_mask} != ens_meta_q) ||
                       (cap_t0 != ens_t0_q) || (cap_t1 != ens_t1_q);
    sts_o.cap_hdr    = cap_h;
    sts_o.emit_ready = !pend_v_q || out_free;
    sts_o.fin_ready  = !pend_v_q || out_free;
    sts_o.pend_v     = pend_v_q;
  end

  always_comb begin
    new_item = '0;
    case (cmd_i.em_sel)
      dfsp_pkg::EmMisalign: new_item.event_kind = dfsp_pkg::EvMisaligned;
      dfsp_pkg::EmCrc:      new_item.event_kind = dfsp_pkg::EvCrcError;
      dfsp_pkg::EmFull: begin
        new_item.event_kind = dfsp_pkg::EvTableFull;
        new_item.ident      = key_q;
      end
      dfsp_pkg::EmEns0, dfsp_pkg::EmEns1: begin
        new_item.event_kind    = dfsp_pkg::EvEnsemble;
        new_item.ident         = cap_id;
        new_item.label_charset = cap_h[7:4];
        new_item.short_mask    = cap_mask;
        new_item.part_index    = (cmd_i.em_sel == dfsp_pkg::EmEns1);
        new_item.label_part    = new_item.part_index ? cap_t1 : cap_t0;
      end
      default: begin
        new_item.event_kind    = dfsp_pkg::EvService;
        new_item.ident         = key_q;
        new_item.subchannel    = rep_subch_q;
        new_item.dab_plus      = rep_plus_q;
        new_item.label_charset = rep_cs_q;
        new_item.short_mask    = rep_mask_q;
        new_item.part_index    = (cmd_i.em_sel == dfsp_pkg::EmSvc1);
        new_item.label_part    = new_item.part_index ? rep_t1_q : rep_t0_q;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      fib_q[pos_q] <= byte_i;
      if (pos_q == 5'd0) begin
        crc_q <= dfsp_pkg::crc_byte(16'hFFFF, byte_i);
      end else if (pos_q < 5'(dfsp_pkg::CrcBytes)) begin
        crc_q <= dfsp_pkg::crc_byte(crc_q, byte_i);
      end
    end
    if (cmd_i.cap_shift) cap_q <= {cap_q[159:0], sts_o.rd_byte};
    if (cmd_i.key_hi)    key_q[15:8] <= sts_o.rd_byte;
    if (cmd_i.key_lo)    key_q[7:0]  <= sts_o.rd_byte;
    if (cmd_i.key_cap)   key_q <= cap_id;
    if (cmd_i.cand_load) begin
      rep_subch_q <= sts_o.rd_byte[7:2];
      rep_plus_q  <= cmd_i.cand_plus;
    end
    if (cmd_i.rep_label) begin
      rep_cs_q   <= lm_rd_q[19:16];
      rep_mask_q <= lm_rd_q[15:0];
    end
    if (cmd_i.rep_t0) rep_t0_q <= tm_rd_q;
    if (cmd_i.rep_t1) rep_t1_q <= tm_rd_q;
    if (cmd_i.rep_cap) begin
      rep_cs_q   <= cap_h[7:4];
      rep_mask_q <= cap_mask;
      rep_t0_q   <= cap_t0;
      rep_t1_q   <= cap_t1;
    end
    if (cmd_i.rep_audio) begin
      rep_subch_q <= am_rd_q[6:1];
      rep_plus_q  <= am_rd_q[0];
    end
    if (cmd_i.ens_upd) begin
      ens_id_q   <= cap_id;
      ens_meta_q <= {cap_h[7:4], cap_mask};
      ens_t0_q   <= cap_t0;
      ens_t1_q   <= cap_t1;
    end
    if (cmd_i.emit && (res_cnt_q < 4'(dfsp_pkg::MaxResults))) begin
      pend_q <= new_item;
      if (pend_v_q) begin
        out_q      <= pend_q;
        out_last_q <= 1'b0;
      end
    end else if (cmd_i.finish && pend_v_q) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  // service table memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.am_wr) am_mem[audio_cnt_q[Iw-1:0]] <= {key_q, rep_subch_q, rep_plus_q};
    if (cmd_i.am_rd) am_rd_q <= am_mem[cmd_i.idx[Iw-1:0]];
    if (cmd_i.lm_wr) lm_mem[label_cnt_q[Iw-1:0]] <= {key_q, rep_cs_q, rep_mask_q};
    if (cmd_i.lm_rd) lm_rd_q <= lm_mem[cmd_i.idx[Iw-1:0]];
    if (cmd_i.tm_wr) tm_mem[tm_addr_w] <= cmd_i.tm_hi ? rep_t1_q : rep_t0_q;
    if (cmd_i.tm_rd) tm_rd_q <= tm_mem[tm_addr_r];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      audio_cnt_q <= '0;
      label_cnt_q <= '0;
      reported_q  <= '0;
      ens_known_q <= 1'b0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      res_cnt_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        pos_q <= (sts_o.pos_last || cmd_i.finish) ? 5'd0 : pos_q + 5'd1;
      end
      if (cmd_i.am_wr) audio_cnt_q <= audio_cnt_q + dfsp_pkg::CntW'(1);
      if (cmd_i.lm_wr) label_cnt_q <= label_cnt_q + dfsp_pkg::CntW'(1);
      if (cmd_i.set_rep) reported_q[cmd_i.rep_idx] <= 1'b1;
      if (cmd_i.ens_upd) ens_known_q <= 1'b1;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (cmd_i.emit && (res_cnt_q < 4'(dfsp_pkg::MaxResults))) begin
        res_cnt_q <= res_cnt_q + 4'd1;
        pend_v_q  <= 1'b1;
        if (pend_v_q) out_v_q <= 1'b1;
      end else if (cmd_i.finish) begin
        res_cnt_q <= '0;
        pend_v_q  <= 1'b0;
        if (pend_v_q) out_v_q <= 1'b1;
      end
      // a call end before byte 31 drops the partial fib
      if (cmd_i.emit && (cmd_i.em_sel == dfsp_pkg::EmMisalign)) pos_q <= 5'd0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_last_o  = out_last_q;
  assign out_item_o  = out_q;

endmodule

[rtl/dab_fib_service_parser_top.sv]
// fib service parser: one fic byte per cycle is taken while idle; bytes 0..30 without a
// call end leave the block idle, a call end that completes no fib emits a misaligned event
// byte 31 starts crc check and fig walk; each search reads its table one entry at a time
// (single read port per table memory); results leave one per cycle while the receiver is
// ready, through a one-item hold and an output register
// reset (async, active low) empties both service tables and forgets the ensemble; no clear pass
module dab_fib_service_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] fic_byte
  input  logic         s_axis_tlast_i,   // call_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [111:0] m_axis_tdata_o,   // event_kind, ident, subchannel, dab_plus,
                                         // label_charset, short_mask, label_part, part_index
  output logic         m_axis_tlast_o    // last
);

  dfsp_pkg::cmd_t  cmd;
  dfsp_pkg::sts_t  sts;
  dfsp_pkg::item_t item;

  // fsm: walks the fib and sequences searches and result transactions
  dfsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, crc, tables and output stage
  dfsp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_last_o  (m_axis_tlast_o),
    .out_item_o  (item)
  );

  // fields packed from the lowest bit up, one pad bit on top
  assign m_axis_tdata_o = {1'b0, item.part_index, item.label_part, item.short_mask,
                           item.label_charset, item.dab_plus, item.subchannel,
                           item.ident, item.event_kind};

  // a new byte is only taken once the previous step flushed its results
  a_accept_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !sts.pend_v)
    else $error("byte taken while a result is still held");

  // a result is only pushed when the hold stage can move on
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.emit_ready)
    else $error("result pushed without room");

  // no audio entry is written into a full table
  a_audio_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.am_wr |-> (sts.audio_cnt != dfsp_pkg::CntW'(dfsp_pkg::MaxServices)))
    else $error("audio table overrun");

endmodule

[verif/dab_fib_service_parser_top_tb.sv]
// self-checking testbench for dab_fib_service_parser_top: streams fic bytes, predicts the
// event items in a behavioral model and checks every output transaction; uses dfsp_pkg
module dab_fib_service_parser_top_tb;
  import dfsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSvc    = MaxServices;
  localparam int IdleLimit = 40000;
  localparam int HoldLen   = 3000;

  typedef logic [7:0] fib_t [32];
  typedef struct {
    logic [7:0] fic;
    logic       call_end;
  } fic_txn_t;
  typedef struct {
    logic [2:0]  kind;
    logic [15:0] ident;
    logic [5:0]  subch;
    logic        plus;
    logic [3:0]  cs;
    logic [15:0] mask;
    logic [63:0] part;
    logic        idx;
    logic        last;
  } event_txn_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;

  dab_fib_service_parser_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model state
  logic [7:0]  mdl_fib [32];
  int          mdl_pos;
  logic        aud_valid [NumSvc];
  logic        aud_rep   [NumSvc];
  logic [15:0] aud_sid   [NumSvc];
  logic [5:0]  aud_subch [NumSvc];
  logic        aud_plus  [NumSvc];
  logic        lab_valid [NumSvc];
  logic [15:0] lab_sid   [NumSvc];
  logic [3:0]  lab_cs    [NumSvc];
  logic [15:0] lab_mask  [NumSvc];
  logic [63:0] lab_text  [2*NumSvc];
  logic        ens_known;
  logic [15:0] ens_id;
  logic [19:0] ens_meta;
  logic [63:0] ens_text [2];

  fic_txn_t   fic_pending [$];
  event_txn_t step_events [$];
  event_txn_t event_expect [$];

  int  mismatches = 0;
  bit  in_flight_done = 1'b0;
  int  bytes_sent = 0;
  bit  calm = 1'b0;     // stretch with no idling on either side

  function automatic logic [15:0] crc_ccitt(fib_t f);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < CrcBytes; i++) begin
      c = c ^ {f[i], 8'h00};
      for (int b = 0; b < 8; b++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return ~c;
  endfunction

  function automatic void push_event(logic [2:0] k, logic [15:0] id, logic [5:0] sc,
                                     logic pl, logic [3:0] cs, logic [15:0] mk,
                                     logic [63:0] pt, logic ix);
    event_txn_t e;
    if (step_events.size() >= MaxResults) return;
    e = '{k, id, sc, pl, cs, mk, pt, ix, 1'b0};
    step_events.push_back(e);
  endfunction

  function automatic int audio_slot(logic [15:0] sid);
    for (int i = 0; i < NumSvc; i++) if (aud_valid[i] && aud_sid[i] == sid) return i;
    return -1;
  endfunction

  function automatic int label_slot(logic [15:0] sid);
    for (int i = 0; i < NumSvc; i++) if (lab_valid[i] && lab_sid[i] == sid) return i;
    return -1;
  endfunction

  // a service is reported once it has both an audio entry and a label
  function automatic void report_service(logic [15:0] sid);
    int a, l;
    a = audio_slot(sid);
    if (a < 0 || aud_rep[a]) return;
    l = label_slot(sid);
    if (l < 0) return;
    aud_rep[a] = 1'b1;
    for (int h = 0; h < 2; h++)
      push_event(EvService, sid, aud_subch[a], aud_plus[a], lab_cs[l], lab_mask[l],
                 lab_text[2*l+h], h[0]);
  endfunction

  function automatic void walk_fig0(int p, int stop);
    logic [7:0] h, b0, b1;
    logic pd;
    logic [15:0] sid;
    int pos, n, i;
    if (p >= stop) return;
    h = mdl_fib[p];
    if ((h & 8'hC0) != 0 || h[4:0] != Fig0Ext) return;
    pd = h[5];
    pos = p + 1;
    while (pos < stop) begin
      sid = '0;
      if (pos + (pd ? 5 : 3) > stop) return;
      if (pd) pos += 4;
      else begin
        sid = {mdl_fib[pos], mdl_fib[pos+1]};
        pos += 2;
      end
      n = mdl_fib[pos] & 8'h0F;
      pos++;
      for (int k = 0; k < n; k++) begin
        if (pos + 2 > stop) return;
        b0 = mdl_fib[pos];
        b1 = mdl_fib[pos+1];
        if (!pd && b0[7:6] == 2'b00 && b1[1] && !b1[0] &&
            (b0[5:0] == 6'd0 || b0[5:0] == AsctyPlus) && audio_slot(sid) < 0) begin
          for (i = 0; i < NumSvc && aud_valid[i]; i++) ;
          if (i >= NumSvc) push_event(EvTableFull, sid, '0, 1'b0, '0, '0, '0, 1'b0);
          else begin
            aud_valid[i] = 1'b1;
            aud_rep[i]   = 1'b0;
            aud_sid[i]   = sid;
            aud_subch[i] = b1[7:2];
            aud_plus[i]  = (b0[5:0] == AsctyPlus);
            report_service(sid);
          end
        end
        pos += 2;
      end
    end
  endfunction

  function automatic void walk_fig1(int p, int len);
    logic [7:0] h;
    logic [15:0] id, mk;
    logic [63:0] t0, t1;
    logic [19:0] meta;
    int i;
    if (len != Fig1Len || p + len > CrcBytes) return;
    h = mdl_fib[p];
    if (h[2:0] > 3'd1 || h[3]) return;
    id = {mdl_fib[p+1], mdl_fib[p+2]};
    for (int j = 0; j < 8; j++) begin
      t0 = {t0[55:0], mdl_fib[p+3+j]};
      t1 = {t1[55:0], mdl_fib[p+11+j]};
    end
    mk = {mdl_fib[p+19], mdl_fib[p+20]};
    if (h[2:0] == 3'd0) begin
      meta = {h[7:4], mk};
      if (!ens_known || id != ens_id || meta != ens_meta || t0 != ens_text[0] ||
          t1 != ens_text[1]) begin
        ens_known = 1'b1;
        ens_id = id;
        ens_meta = meta;
        ens_text[0] = t0;
        ens_text[1] = t1;
        push_event(EvEnsemble, id, '0, 1'b0, h[7:4], mk, t0, 1'b0);
        push_event(EvEnsemble, id, '0, 1'b0, h[7:4], mk, t1, 1'b1);
      end
      return;
    end
    if (label_slot(id) >= 0) return;
    for (i = 0; i < NumSvc && lab_valid[i]; i++) ;
    if (i >= NumSvc) begin
      push_event(EvTableFull, id, '0, 1'b0, '0, '0, '0, 1'b0);
      return;
    end
    lab_valid[i] = 1'b1;
    lab_sid[i] = id;
    lab_cs[i] = h[7:4];
    lab_mask[i] = mk;
    lab_text[2*i] = t0;
    lab_text[2*i+1] = t1;
    report_service(id);
  endfunction

  function automatic void parse_fib();
    fib_t f;
    int off, len, p, stop;
    logic [2:0] ty;
    for (int i = 0; i < 32; i++) f[i] = mdl_fib[i];
    if ({mdl_fib[30], mdl_fib[31]} != crc_ccitt(f)) begin
      push_event(EvCrcError, '0, '0, 1'b0, '0, '0, '0, 1'b0);
      return;
    end
    off = 0;
    while (off < CrcBytes && mdl_fib[off] != EndMarker) begin
      ty = mdl_fib[off][7:5];
      len = mdl_fib[off][4:0];
      p = off + 1;
      stop = (p + len > CrcBytes) ? CrcBytes : p + len;
      if (len >= 1) begin
        if (ty == 3'd0) walk_fig0(p, stop);
        else if (ty == 3'd1) walk_fig1(p, len);
      end
      off = p + len;
    end
  endfunction

  // one accepted fic byte -> expected event items
  function automatic void predict_byte(fic_txn_t t);
    step_events.delete();
    mdl_fib[mdl_pos] = t.fic;
    if (mdl_pos == 31) begin
      mdl_pos = 0;
      parse_fib();
    end else begin
      mdl_pos++;
      if (t.call_end) begin
        mdl_pos = 0;
        push_event(EvMisaligned, '0, '0, 1'b0, '0, '0, '0, 1'b0);
      end
    end
    if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
    foreach (step_events[i]) event_expect.push_back(step_events[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void queue_fib(fib_t f);
    fic_txn_t t;
    for (int i = 0; i < 32; i++) begin
      t.fic = f[i];
      t.call_end = (i == 31) ? 1'($urandom_range(0, 1)) : 1'b0;
      fic_pending.push_back(t);
    end
  endfunction

  function automatic void seal_fib(inout fib_t f, input bit corrupt);
    logic [15:0] c;
    c = crc_ccitt(f);
    if (corrupt) c ^= 16'(1 << $urandom_range(0, 15));
    f[30] = c[15:8];
    f[31] = c[7:0];
  endfunction

  function automatic logic [15:0] pick_sid();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'h4000 + 16'($urandom_range(0, 79));
  endfunction

  // well-formed fib: optional fig 1 label, then fig 0/2 services, then end marker
  function automatic void build_fib(output fib_t f);
    int at, room, nsvc;
    logic [15:0] sid;
    logic [7:0] hdr, ascty;
    for (int i = 0; i < 32; i++) f[i] = EndMarker;
    at = 0;
    if ($urandom_range(0, 4) != 0) begin
      hdr = {4'($urandom), 1'b0, 3'd1};
      if ($urandom_range(0, 5) == 0) hdr[2:0] = 3'd0;
      if ($urandom_range(0, 19) == 0) hdr[3] = 1'b1;
      if ($urandom_range(0, 19) == 0) hdr[2:0] = 3'($urandom_range(2, 7));
      sid = (hdr[2:0] == 3'd0) ? (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hCE15)
                               : pick_sid();
      f[0] = {3'd1, 5'd21};
      f[1] = hdr;
      f[2] = sid[15:8];
      f[3] = sid[7:0];
      for (int i = 4; i < 22; i++) f[i] = 8'($urandom);
      at = 22;
    end
    room = CrcBytes - at;
    nsvc = (room - 2) / 5;
    if (nsvc > 1) nsvc = $urandom_range(1, nsvc);
    if (nsvc >= 1) begin
      f[at] = {3'd0, 5'(1 + 5 * nsvc)};
      f[at+1] = {2'b00, 1'b0, Fig0Ext};
      if ($urandom_range(0, 9) == 0) f[at+1][5] = 1'b1;
      if ($urandom_range(0, 19) == 0) f[at+1][7:6] = 2'($urandom_range(1, 3));
      for (int s = 0; s < nsvc; s++) begin
        sid = pick_sid();
        ascty = ($urandom_range(0, 2) == 0) ? 8'h3F : 8'h00;
        if ($urandom_range(0, 9) == 0) ascty = 8'($urandom);
        f[at+2+5*s] = sid[15:8];
        f[at+3+5*s] = sid[7:0];
        f[at+4+5*s] = 8'h01;
        f[at+5+5*s] = ascty;
        f[at+6+5*s] = {6'($urandom), 1'b1, ($urandom_range(0, 9) == 0)};
      end
    end
    seal_fib(f, 1'b0);
  endfunction

  function automatic void queue_short_call(int n);
    fic_txn_t t;
    for (int i = 0; i < n; i++) begin
      t.fic = 8'($urandom);
      t.call_end = (i == n - 1);
      fic_pending.push_back(t);
    end
  endfunction

  function automatic void queue_directed();
    fib_t f;
    // ensemble label, then the same again: only the first reports
    for (int i = 0; i < 32; i++) f[i] = EndMarker;
    f[0] = {3'd1, 5'd21};
    f[1] = 8'hF0;
    f[2] = 8'hFF;
    f[3] = 8'hFF;
    for (int i = 4; i < 22; i++) f[i] = 8'h00;
    seal_fib(f, 1'b0);
    queue_fib(f);
    queue_fib(f);
    // dab+ audio service with its label in one fib
    for (int i = 0; i < 32; i++) f[i] = EndMarker;
    f[0] = {3'd1, 5'd21};
    f[1] = 8'h01;
    f[2] = 8'h00;
    f[3] = 8'h00;
    for (int i = 4; i < 22; i++) f[i] = 8'hFF;
    f[22] = {3'd0, 5'd6};
    f[23] = 8'h02;
    f[24] = 8'h00;
    f[25] = 8'h00;
    f[26] = 8'h01;
    f[27] = 8'h3F;
    f[28] = 8'hFE;
    seal_fib(f, 1'b0);
    queue_fib(f);
    // data service, unknown fig type, fig cut at the payload end
    for (int i = 0; i < 32; i++) f[i] = EndMarker;
    f[0] = {3'd0, 5'd8};
    f[1] = 8'h22;
    f[9] = {3'd7, 5'd2};
    f[12] = {3'd0, 5'd31};
    f[13] = 8'h02;
    f[14] = 8'h12;
    f[15] = 8'h34;
    f[16] = 8'h0F;
    seal_fib(f, 1'b0);
    queue_fib(f);
    // fib of empty figs with a corrupt crc, then misaligned call ends
    for (int i = 0; i < 32; i++) f[i] = 8'h00;
    seal_fib(f, 1'b1);
    queue_fib(f);
    queue_short_call(1);
    queue_short_call(31);
  endfunction

  // ---------------------------------------------------------------- driver
  // accept at the rising edge, drive the next byte at the falling edge
  bit in_accepted;
  bit out_accepted;
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    in_accepted = s_axis_tvalid_i && s_axis_tready_o;
    if (in_accepted) begin
      predict_byte(fic_pending.pop_front());
      bytes_sent++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && !in_accepted) begin
        // hold the offered transaction until it is taken
      end else if (fic_pending.size() > 0 && (calm || $urandom_range(0, 99) >= 18)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= fic_pending[0].fic;
        s_axis_tlast_i  <= fic_pending[0].call_end;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && bytes_sent >= 400) begin
        hold_done <= 1'b1;
        hold_left <= HoldLen;
        m_axis_tready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    event_txn_t e;
    logic [111:0] d;
    out_accepted = m_axis_tvalid_o && m_axis_tready_i;
    if (out_accepted) begin
      d = m_axis_tdata_o;
      if (event_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transaction tdata=%h", d);
      end else begin
        e = event_expect.pop_front();
        if (d[2:0] != e.kind || d[18:3] != e.ident || d[24:19] != e.subch ||
            d[25] != e.plus || d[29:26] != e.cs || d[45:30] != e.mask ||
            d[109:46] != e.part || d[110] != e.idx || m_axis_tlast_o != e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d id=%h sc=%0d plus=%0b cs=%h mask=%h part=%h idx=%0b last=%0b | act kind=%0d id=%h sc=%0d plus=%0b cs=%h mask=%h part=%h idx=%0b last=%0b",
                     e.kind, e.ident, e.subch, e.plus, e.cs, e.mask, e.part, e.idx, e.last,
                     d[2:0], d[18:3], d[24:19], d[25], d[29:26], d[45:30], d[109:46],
                     d[110], m_axis_tlast_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (in_accepted || out_accepted || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !in_flight_done) begin
      $display("dab_fib_service_parser_top_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    fib_t f;
    int pick;
    mdl_pos = 0;
    ens_known = 1'b0;
    ens_id = '0;
    ens_meta = '0;
    ens_text[0] = '0;
    ens_text[1] = '0;
    for (int i = 0; i < NumSvc; i++) begin
      aud_valid[i] = 1'b0;
      aud_rep[i] = 1'b0;
      lab_valid[i] = 1'b0;
    end
    queue_directed();
    // enough fibs that both service tables overflow
    for (int n = 0; n < 110; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        build_fib(f);
        queue_fib(f);
      end else if (pick < 88) begin
        for (int i = 0; i < 32; i++) f[i] = 8'($urandom);
        seal_fib(f, 1'b0);
        queue_fib(f);
      end else if (pick < 94) begin
        build_fib(f);
        f[$urandom_range(0, 31)] ^= 8'(1 << $urandom_range(0, 7));
        queue_fib(f);
      end else begin
        queue_short_call($urandom_range(1, 31));
      end
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (bytes_sent >= 1500);
    calm = 1'b1;
    wait (bytes_sent >= 2000 || fic_pending.size() == 0);
    calm = 1'b0;
    wait (fic_pending.size() == 0 && event_expect.size() == 0);
    in_flight_done = 1'b1;
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && event_expect.size() == 0)
      $display("dab_fib_service_parser_top_tb passed");
    else
      $display("dab_fib_service_parser_top_tb failed");
    $finish;
  end

endmodule
